// ===== hdl/cwmf_pkg.sv =====
// Package for the clipped window median filter.
// Holds the controller state type, the configuration bundle and register codes.
// No dependencies.
`timescale 1ns / 1ps

package cwmf_pkg;

   localparam int CHANNELS   = 3;
   localparam int PIX_W      = 8;
   localparam int ROW_W      = 13;
   localparam int MAX_HEIGHT = 4096;

   // register indexes (word address bits [3:2])
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [1:0] REG_WIN_SIDE     = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_SCAN,
      ST_SETTLE,
      ST_DECIDE,
      ST_PUT
   } state_type;

   typedef struct packed {
      logic [11:0] image_width;
      logic [12:0] image_height;
      logic [2:0]  win_side;
      logic        restart;
   } cfg_type;

endpackage

// ===== hdl/cwmf_ifs.sv =====
// Stream interfaces of the median filter: pixel request and filtered response.
// Valid/ready handshake, a word moves when both are high. No dependencies.
`timescale 1ns / 1ps

interface cwmf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_in;
   logic [7:0] green_in;
   logic [7:0] blue_in;
   logic       flush;

   modport source (output valid, red_in, green_in, blue_in, flush, input ready);
   modport sink   (input valid, red_in, green_in, blue_in, flush, output ready);
endinterface

interface cwmf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red_out;
   logic [7:0] green_out;
   logic [7:0] blue_out;
   logic       end_of_frame;
   logic       window_error;

   modport source (output valid, red_out, green_out, blue_out, end_of_frame,
                   window_error, input ready);
   modport sink   (input valid, red_out, green_out, blue_out, end_of_frame,
                   window_error, output ready);
endinterface

// ===== hdl/cwmf_csr.sv =====
// APB-style configuration registers of the median filter.
// Depends on cwmf_pkg for the configuration bundle and register codes.
`timescale 1ns / 1ps

module cwmf_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [3:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output cwmf_pkg::cfg_type cfg
);
   import cwmf_pkg::*;

   logic [11:0] width_ff,  width_in;
   logic [12:0] height_ff, height_in;
   logic [2:0]  win_ff,    win_in;
   logic        wr;
   logic        restart;
   logic [1:0]  idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[3:2];

   // register write decode
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      win_in    = win_ff;
      restart   = 1'b0;
      if (wr) begin
         case (idx)
            REG_IMAGE_WIDTH: begin
               width_in = csr_pwdata[11:0];
               restart  = 1'b1;
            end
            REG_IMAGE_HEIGHT: begin
               height_in = csr_pwdata[12:0];
               restart   = 1'b1;
            end
            REG_WIN_SIDE: begin
               win_in  = csr_pwdata[2:0];
               restart = 1'b1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 12'd640;
         height_ff <= 13'd480;
         win_ff    <= 3'd3;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         win_ff    <= win_in;
      end
   end

   // read back
   always_comb begin
      case (idx)
         REG_IMAGE_WIDTH:  csr_prdata = {20'd0, width_ff};
         REG_IMAGE_HEIGHT: csr_prdata = {19'd0, height_ff};
         REG_WIN_SIDE:     csr_prdata = {29'd0, win_ff};
         default:          csr_prdata = 32'd0;
      endcase
   end

   assign cfg.image_width  = width_ff;
   assign cfg.image_height = height_ff;
   assign cfg.win_side     = win_ff;
   assign cfg.restart      = restart;

endmodule

// ===== hdl/cwmf_line_store.sv =====
// Line store: a ring of row buffers holding RGB pixels, one write and one read port.
// Read data is registered. Depends on cwmf_pkg.
`timescale 1ns / 1ps

module cwmf_line_store #(
   parameter int SLOTS     = 8,
   parameter int MAX_WIDTH = 2048
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(SLOTS)-1:0]     wr_slot,
   input  logic [$clog2(MAX_WIDTH)-1:0] wr_col,
   input  logic [23:0]                  wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(SLOTS)-1:0]     rd_slot,
   input  logic [$clog2(MAX_WIDTH)-1:0] rd_col,
   output logic [23:0]                  rd_data
);
   import cwmf_pkg::*;

   logic [CHANNELS*PIX_W-1:0] mem [SLOTS][MAX_WIDTH];
   logic [CHANNELS*PIX_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_slot][wr_col] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_slot][rd_col];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cwmf_core.sv =====
// Median filter controller: frame counters, window scan over the line store
// and bitwise rank selection per channel. Depends on cwmf_pkg and cwmf_ifs.
`timescale 1ns / 1ps

module cwmf_core #(
   parameter int MAX_WINDOW = 7,
   parameter int MAX_WIDTH  = 2048
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cwmf_pkg::cfg_type      cfg,
   cwmf_req_if.sink               req_ch,
   cwmf_rsp_if.source             rsp_ch,
   output logic                   mem_wr_en,
   output logic [$clog2(MAX_WINDOW+1)-1:0] mem_wr_slot,
   output logic [$clog2(MAX_WIDTH)-1:0]    mem_wr_col,
   output logic [23:0]            mem_wr_data,
   output logic                   mem_rd_en,
   output logic [$clog2(MAX_WINDOW+1)-1:0] mem_rd_slot,
   output logic [$clog2(MAX_WIDTH)-1:0]    mem_rd_col,
   input  logic [23:0]            mem_rd_data
);
   import cwmf_pkg::*;

   localparam int SLOTS = MAX_WINDOW + 1;
   localparam int SB    = $clog2(SLOTS);
   localparam int CB    = $clog2(MAX_WIDTH);
   localparam int WB    = $clog2(MAX_WIDTH + 1);
   localparam int NB    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int WIN_CLAMP = (MAX_WINDOW - 1) | 1;

   state_type state_ff, state_in;

   logic [CB-1:0]    in_col_ff,  in_col_in;
   logic [ROW_W-1:0] in_row_ff,  in_row_in;
   logic [SB-1:0]    in_slot_ff, in_slot_in;
   logic [CB-1:0]    out_col_ff,  out_col_in;
   logic [11:0]      out_row_ff,  out_row_in;
   logic [SB-1:0]    out_slot_ff, out_slot_in;

   logic [23:0] px_ff, px_in;
   logic        flush_ff, flush_in;
   logic        eof_ff, eof_in;
   logic        err_ff, err_in;

   logic [CB-1:0] q_ff, q_in, c0_ff, c0_in, c1_ff, c1_in;
   logic [SB-1:0] slot_ff, slot_in, slot0_ff, slot0_in;
   logic [2:0]    rows_ff, rows_in, nrows_ff, nrows_in;
   logic [NB-1:0] n_ff, n_in;
   logic [NB-1:0] cnt_ff [CHANNELS];
   logic [NB-1:0] cnt_in [CHANNELS];
   logic [NB-1:0] k_ff [CHANNELS];
   logic [NB-1:0] k_in [CHANNELS];
   logic [7:0]    pre_ff [CHANNELS];
   logic [7:0]    pre_in [CHANNELS];
   logic [7:0]    mask_ff, mask_in, bit_ff, bit_in;
   logic          rd_vld_ff, rd_vld_in;

   logic        ovld_ff, ovld_in;
   logic [23:0] odata_ff, odata_in;
   logic        oeof_ff, oeof_in, oerr_ff, oerr_in;

   // effective configuration
   logic [WB-1:0]    w_eff;
   logic [ROW_W-1:0] h_eff;
   logic [2:0]       win_c;
   logic [1:0]       m;
   logic             even;

   always_comb begin
      if (cfg.image_width == 12'd0) w_eff = WB'(1);
      else if (32'(cfg.image_width) > MAX_WIDTH) w_eff = WB'(MAX_WIDTH);
      else w_eff = WB'(cfg.image_width);
      if (cfg.image_height == 13'd0) h_eff = ROW_W'(1);
      else if (32'(cfg.image_height) > MAX_HEIGHT) h_eff = ROW_W'(MAX_HEIGHT);
      else h_eff = cfg.image_height;
      if (32'(cfg.win_side) > MAX_WINDOW) win_c = 3'(WIN_CLAMP);
      else win_c = cfg.win_side;
   end
   assign m    = win_c[2:1];
   assign even = ~cfg.win_side[0];

   // window bounds of the next output pixel
   logic [ROW_W-1:0] hm1, row_sum, hr, r0;
   logic [WB:0]      wm1, col_sum, wc, c0w;
   logic [1:0]       d;
   logic [SB+1:0]    slot_tmp;
   logic [SB-1:0]    slot_r0;
   logic             produce, out_eof;

   always_comb begin
      hm1     = h_eff - ROW_W'(1);
      row_sum = ROW_W'(out_row_ff) + ROW_W'(m);
      hr      = (row_sum > hm1) ? hm1 : row_sum;
      r0      = (out_row_ff > 12'(m)) ? ROW_W'(out_row_ff - 12'(m)) : '0;
      d       = 2'(ROW_W'(out_row_ff) - r0);
      wm1     = (WB+1)'(w_eff) - (WB+1)'(1);
      col_sum = (WB+1)'(out_col_ff) + (WB+1)'(m);
      wc      = (col_sum > wm1) ? wm1 : col_sum;
      c0w     = ((WB+1)'(out_col_ff) > (WB+1)'(m)) ?
                (WB+1)'(out_col_ff) - (WB+1)'(m) : '0;
      slot_tmp = (SB+2)'(out_slot_ff) + (SB+2)'(SLOTS) - (SB+2)'(d);
      if (slot_tmp >= (SB+2)'(SLOTS)) slot_tmp = slot_tmp - (SB+2)'(SLOTS);
      slot_r0 = SB'(slot_tmp);
      produce = (in_row_ff > hr) ||
                ((in_row_ff == hr) && ((WB+1)'(in_col_ff) > wc));
      out_eof = (ROW_W'(out_row_ff) == hm1) && ((WB+1)'(out_col_ff) == wm1);
   end

   logic accept, last_col, in_last_col, in_eof;
   assign accept = req_ch.valid & req_ch.ready;
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign in_last_col = (WB'(in_col_ff) + WB'(1)) >= w_eff;
   assign in_eof = (in_row_ff == hm1) && (WB'(in_col_ff) == WB'(w_eff - WB'(1)));
   assign last_col = (q_ff == c1_ff);

   function automatic logic [SB-1:0] slot_next(input logic [SB-1:0] s);
      return (s == SB'(SLOTS - 1)) ? '0 : s + SB'(1);
   endfunction

   // next state and datapath
   always_comb begin
      logic [NB-1:0] ke;
      logic [7:0]    e;
      ke          = '0;
      e           = '0;
      state_in    = state_ff;
      in_col_in   = in_col_ff;
      in_row_in   = in_row_ff;
      in_slot_in  = in_slot_ff;
      out_col_in  = out_col_ff;
      out_row_in  = out_row_ff;
      out_slot_in = out_slot_ff;
      px_in       = px_ff;
      flush_in    = flush_ff;
      eof_in      = eof_ff;
      err_in      = err_ff;
      q_in        = q_ff;
      c0_in       = c0_ff;
      c1_in       = c1_ff;
      slot_in     = slot_ff;
      slot0_in    = slot0_ff;
      rows_in     = rows_ff;
      nrows_in    = nrows_ff;
      n_in        = n_ff;
      mask_in     = mask_ff;
      bit_in      = bit_ff;
      ovld_in     = ovld_ff & ~rsp_ch.ready;
      odata_in    = odata_ff;
      oeof_in     = oeof_ff;
      oerr_in     = oerr_ff;
      mem_wr_en   = 1'b0;
      mem_rd_en   = 1'b0;
      rd_vld_in   = 1'b0;
      for (int c = 0; c < CHANNELS; c++) begin
         cnt_in[c] = cnt_ff[c];
         k_in[c]   = k_ff[c];
         pre_in[c] = pre_ff[c];
      end

      // count the word returned by the line store
      if (rd_vld_ff) begin
         if (bit_ff[7]) n_in = n_ff + NB'(1);
         for (int c = 0; c < CHANNELS; c++) begin
            e = mem_rd_data[c*PIX_W +: PIX_W];
            if ((((e ^ pre_ff[c]) & mask_ff) == 8'd0) && ((e & bit_ff) == 8'd0))
               cnt_in[c] = cnt_ff[c] + NB'(1);
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               px_in    = {req_ch.blue_in, req_ch.green_in, req_ch.red_in};
               flush_in = req_ch.flush;
               err_in   = even;
               eof_in   = 1'b0;
               if (even) begin
                  if (!req_ch.flush) begin
                     eof_in = in_eof;
                     if (in_eof) begin
                        in_col_in = '0;
                        in_row_in = '0;
                        in_slot_in = '0;
                        out_col_in = '0;
                        out_row_in = '0;
                        out_slot_in = '0;
                     end else if (in_last_col) begin
                        in_col_in = '0;
                        in_row_in = in_row_ff + ROW_W'(1);
                        in_slot_in = slot_next(in_slot_ff);
                     end else begin
                        in_col_in = in_col_ff + CB'(1);
                     end
                  end
               end else if (!req_ch.flush && (in_row_ff < h_eff)) begin
                  mem_wr_en = 1'b1;
                  if (in_last_col) begin
                     in_col_in = '0;
                     in_row_in = in_row_ff + ROW_W'(1);
                     in_slot_in = slot_next(in_slot_ff);
                  end else begin
                     in_col_in = in_col_ff + CB'(1);
                  end
               end
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (err_ff) begin
               state_in = flush_ff ? ST_IDLE : ST_PUT;
            end else if (produce) begin
               eof_in   = out_eof;
               q_in     = CB'(c0w);
               c0_in    = CB'(c0w);
               c1_in    = CB'(wc);
               slot_in  = slot_r0;
               slot0_in = slot_r0;
               rows_in  = 3'(hr - r0);
               nrows_in = 3'(hr - r0);
               n_in     = '0;
               mask_in  = 8'h00;
               bit_in   = 8'h80;
               for (int c = 0; c < CHANNELS; c++) begin
                  cnt_in[c] = '0;
                  pre_in[c] = 8'h00;
               end
               state_in = ST_SCAN;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            mem_rd_en = 1'b1;
            rd_vld_in = 1'b1;
            if (last_col) begin
               q_in = c0_ff;
               if (rows_ff == 3'd0) begin
                  state_in = ST_SETTLE;
               end else begin
                  rows_in = rows_ff - 3'd1;
                  slot_in = slot_next(slot_ff);
               end
            end else begin
               q_in = q_ff + CB'(1);
            end
         end
         ST_SETTLE: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // fix one bit of each channel's median
            for (int c = 0; c < CHANNELS; c++) begin
               ke = bit_ff[7] ? (n_ff >> 1) : k_ff[c];
               if (ke < cnt_ff[c]) begin
                  k_in[c] = ke;
               end else begin
                  k_in[c]   = ke - cnt_ff[c];
                  pre_in[c] = pre_ff[c] | bit_ff;
               end
               cnt_in[c] = '0;
            end
            mask_in  = (mask_ff >> 1) | 8'h80;
            bit_in   = bit_ff >> 1;
            q_in     = c0_ff;
            slot_in  = slot0_ff;
            rows_in  = nrows_ff;
            state_in = bit_ff[0] ? ST_PUT : ST_SCAN;
         end
         ST_PUT: begin
            if (!ovld_ff || rsp_ch.ready) begin
               ovld_in  = 1'b1;
               odata_in = err_ff ? px_ff : {pre_ff[2], pre_ff[1], pre_ff[0]};
               oeof_in  = eof_ff;
               oerr_in  = err_ff;
               if (!err_ff) begin
                  if (eof_ff) begin
                     in_col_in = '0;
                     in_row_in = '0;
                     in_slot_in = '0;
                     out_col_in = '0;
                     out_row_in = '0;
                     out_slot_in = '0;
                  end else if ((WB'(out_col_ff) + WB'(1)) >= w_eff) begin
                     out_col_in  = '0;
                     out_row_in  = out_row_ff + 12'd1;
                     out_slot_in = slot_next(out_slot_ff);
                  end else begin
                     out_col_in = out_col_ff + CB'(1);
                  end
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // a write to a configuration register restarts the frame
      if (cfg.restart) begin
         in_col_in = '0;
         in_row_in = '0;
         in_slot_in = '0;
         out_col_in = '0;
         out_row_in = '0;
         out_slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         in_col_ff   <= '0;
         in_row_ff   <= '0;
         in_slot_ff  <= '0;
         out_col_ff  <= '0;
         out_row_ff  <= '0;
         out_slot_ff <= '0;
         rd_vld_ff   <= 1'b0;
         ovld_ff     <= 1'b0;
      end else begin
         state_ff    <= state_in;
         in_col_ff   <= in_col_in;
         in_row_ff   <= in_row_in;
         in_slot_ff  <= in_slot_in;
         out_col_ff  <= out_col_in;
         out_row_ff  <= out_row_in;
         out_slot_ff <= out_slot_in;
         rd_vld_ff   <= rd_vld_in;
         ovld_ff     <= ovld_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      flush_ff <= flush_in;
      eof_ff   <= eof_in;
      err_ff   <= err_in;
      q_ff     <= q_in;
      c0_ff    <= c0_in;
      c1_ff    <= c1_in;
      slot_ff  <= slot_in;
      slot0_ff <= slot0_in;
      rows_ff  <= rows_in;
      nrows_ff <= nrows_in;
      n_ff     <= n_in;
      mask_ff  <= mask_in;
      bit_ff   <= bit_in;
      odata_ff <= odata_in;
      oeof_ff  <= oeof_in;
      oerr_ff  <= oerr_in;
      for (int c = 0; c < CHANNELS; c++) begin
         cnt_ff[c] <= cnt_in[c];
         k_ff[c]   <= k_in[c];
         pre_ff[c] <= pre_in[c];
      end
   end

   assign mem_wr_slot = in_slot_ff;
   assign mem_wr_col  = in_col_ff;
   assign mem_wr_data = {req_ch.blue_in, req_ch.green_in, req_ch.red_in};
   assign mem_rd_slot = slot_ff;
   assign mem_rd_col  = q_ff;

   assign rsp_ch.valid        = ovld_ff;
   assign rsp_ch.red_out      = odata_ff[7:0];
   assign rsp_ch.green_out    = odata_ff[15:8];
   assign rsp_ch.blue_out     = odata_ff[23:16];
   assign rsp_ch.end_of_frame = oeof_ff;
   assign rsp_ch.window_error = oerr_ff;

endmodule

// ===== hdl/clipped_window_median_filter.sv =====
// Clipped window median filter, top level.
// Pixels enter in raster order on req_ch, one word per pixel; flush words after
// the frame drain the rows still pending. Filtered pixels leave on rsp_ch, at
// most one per input word, with end_of_frame on the last pixel of the image.
// The CSR port holds image_width (0x0), image_height (0x4), window side (0x8);
// any write to these restarts the frame. Write only while the block is idle.
// Timing: a word is taken in one cycle and checked in the next. A word that
// yields no output returns the block from the check straight to idle. A
// filtered pixel needs 8 bit passes over the clipped window read from the
// line store, one pixel a cycle, for a window of up to 49 pixels. An even
// window size passes pixels through unfiltered, flagged with window_error.
// The result sits in an output register, so a stalled receiver holds back the
// next input only once a second result is ready. Reset is synchronous: the
// counters clear and the registers return to 640 x 480, window 3. The line
// store needs no clearing, every pixel read was written in the same frame.
`timescale 1ns / 1ps

module clipped_window_median_filter #(
   parameter int MAX_WINDOW = 7,
   parameter int MAX_WIDTH  = 2048
) (
   input  logic        clock,
   input  logic        reset,
   cwmf_req_if.sink    req_ch,
   cwmf_rsp_if.source  rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import cwmf_pkg::*;

   localparam int SB = $clog2(MAX_WINDOW + 1);
   localparam int CB = $clog2(MAX_WIDTH);

   cfg_type       cfg;
   logic          wr_en, rd_en;
   logic [SB-1:0] wr_slot, rd_slot;
   logic [CB-1:0] wr_col, rd_col;
   logic [23:0]   wr_data, rd_data;

   cwmf_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   cwmf_line_store #(
      .SLOTS     (MAX_WINDOW + 1),
      .MAX_WIDTH (MAX_WIDTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_slot (wr_slot),
      .wr_col  (wr_col),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_slot (rd_slot),
      .rd_col  (rd_col),
      .rd_data (rd_data)
   );

   cwmf_core #(
      .MAX_WINDOW (MAX_WINDOW),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .mem_wr_en   (wr_en),
      .mem_wr_slot (wr_slot),
      .mem_wr_col  (wr_col),
      .mem_wr_data (wr_data),
      .mem_rd_en   (rd_en),
      .mem_rd_slot (rd_slot),
      .mem_rd_col  (rd_col),
      .mem_rd_data (rd_data)
   );

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for the clipped window median filter.
// Drives pixel words and CSR writes, predicts each filtered pixel in the bench and
// compares it field by field. Needs cwmf_pkg, the stream interfaces and the RTL top.
`timescale 1ns / 1ps

module tb_top;
   import cwmf_pkg::*;

   localparam int WIN_MAX     = 7;
   localparam int WIDTH_MAX   = 2048;
   localparam int ROW_SLOTS   = WIN_MAX + 1;
   localparam int SETTLE_CYC  = 500;
   localparam int STALL_LIMIT = 5000;
   localparam int HOLD_CYC    = 1500;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       eof;
      logic       werr;
   } pixel_out_type;

   logic        clock;
   logic        reset;
   logic        csr_psel, csr_penable, csr_pwrite;
   logic [3:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   cwmf_req_if req_ch ();
   cwmf_rsp_if rsp_ch ();

   clipped_window_median_filter DUT (
      .clock(clock), .reset(reset),
      .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata), .csr_pready(csr_pready)
   );

   // predictor state
   logic [23:0] row_store [ROW_SLOTS][WIDTH_MAX];
   logic [11:0] cfg_width;
   logic [12:0] cfg_height;
   logic [2:0]  cfg_win;
   int unsigned in_col, in_row, out_col, out_row;

   pixel_out_type pending_pixels[$];
   int          error_count;
   int          words_sent;
   int          idle_cycles;
   bit          hold_rsp;
   bit          no_idle;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------- predictor ----------------
   function automatic int unsigned eff_width();
      if (cfg_width == 0) return 1;
      if (cfg_width > WIDTH_MAX) return WIDTH_MAX;
      return cfg_width;
   endfunction

   function automatic int unsigned eff_height();
      if (cfg_height == 0) return 1;
      if (cfg_height > MAX_HEIGHT) return MAX_HEIGHT;
      return cfg_height;
   endfunction

   task automatic restart_frame();
      in_col = 0; in_row = 0; out_col = 0; out_row = 0;
   endtask

   task automatic bump_input(input int unsigned w);
      in_col++;
      if (in_col >= w) begin
         in_col = 0;
         in_row++;
      end
   endtask

   // element n/2 of the ascending order
   function automatic logic [7:0] rank_median(input logic [7:0] v[49], input int n);
      int lt, le;
      for (int i = 0; i < n; i++) begin
         lt = 0; le = 0;
         for (int j = 0; j < n; j++) begin
            if (v[j] < v[i]) lt++;
            if (v[j] <= v[i]) le++;
         end
         if (lt <= n / 2 && n / 2 < le) return v[i];
      end
      return 8'hFF;
   endfunction

   task automatic predict_word(input logic [7:0] r, g, b, input logic fl,
                               output bit has_out, output pixel_out_type res);
      int unsigned w, h, win, m, hr, wc, r0, c0, n;
      logic [7:0]  gathered [3][49];
      bit          eof;
      w = eff_width();
      h = eff_height();
      win = cfg_win;
      has_out = 0;
      res = '{default: '0};
      if (win[0] == 1'b0) begin
         // even window: pass-through, flagged
         if (fl) return;
         if (in_row >= h || in_col >= w) restart_frame();
         eof = (in_row == h - 1) && (in_col == w - 1);
         bump_input(w);
         if (eof) restart_frame();
         res = '{r, g, b, eof, 1'b1};
         has_out = 1;
         return;
      end
      if (win > WIN_MAX) win = (WIN_MAX - 1) | 1;
      m = (win - 1) / 2;
      if (in_row > h || in_col >= w || out_row >= h || out_col >= w) restart_frame();
      if (!fl && in_row < h) begin
         row_store[in_row % ROW_SLOTS][in_col] = {r, g, b};
         bump_input(w);
      end
      hr = out_row + m;
      if (hr > h - 1) hr = h - 1;
      wc = out_col + m;
      if (wc > w - 1) wc = w - 1;
      if (hr * w + wc >= in_row * w + in_col) return;
      r0 = (out_row > m) ? out_row - m : 0;
      c0 = (out_col > m) ? out_col - m : 0;
      n = 0;
      for (int unsigned rr = r0; rr <= hr; rr++)
         for (int unsigned cc = c0; cc <= wc; cc++) begin
            gathered[0][n] = row_store[rr % ROW_SLOTS][cc][23:16];
            gathered[1][n] = row_store[rr % ROW_SLOTS][cc][15:8];
            gathered[2][n] = row_store[rr % ROW_SLOTS][cc][7:0];
            n++;
         end
      res.red   = rank_median(gathered[0], n);
      res.green = rank_median(gathered[1], n);
      res.blue  = rank_median(gathered[2], n);
      eof = (out_row == h - 1) && (out_col == w - 1);
      out_col++;
      if (out_col >= w) begin
         out_col = 0;
         out_row++;
      end
      if (eof) restart_frame();
      res.eof = eof;
      res.werr = 1'b0;
      has_out = 1;
   endtask

   // ---------------- drivers ----------------
   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (idx)
         REG_IMAGE_WIDTH:  cfg_width  = value[11:0];
         REG_IMAGE_HEIGHT: cfg_height = value[12:0];
         REG_WIN_SIDE:     cfg_win    = value[2:0];
         default: ;
      endcase
      restart_frame();
   endtask

   // block must be idle before any register write
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [31:0] w, h, win);
      wait_idle();
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_WIN_SIDE, win);
   endtask

   task automatic send_word(input logic [7:0] r, g, b, input logic fl);
      int            gap;
      bit            has;
      pixel_out_type res;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.red_in   <= r;
      req_ch.green_in <= g;
      req_ch.blue_in  <= b;
      req_ch.flush    <= fl;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      words_sent++;
      predict_word(r, g, b, fl, has, res);
      if (has) pending_pixels.push_back(res);
   endtask

   task automatic send_random_pixel();
      send_word($urandom, $urandom, $urandom, 1'b0);
   endtask

   // flush words (mixed with stray pixels) until the predicted frame completes or 400 words went out
   task automatic drain_frame();
      int guard;
      guard = 0;
      while ((in_col | in_row | out_col | out_row) != 0 && guard < 400) begin
         if ($urandom_range(0, 3) == 0) send_random_pixel();
         else send_word($urandom, $urandom, $urandom, 1'b1);
         guard++;
      end
   endtask

   // one frame: full when count < 0, else only that many pixels
   task automatic run_frame(input int w, h, win, input int count, input int noise_pct);
      int total;
      set_geometry(w, h, win);
      total = (count < 0) ? eff_width() * eff_height() : count;
      for (int i = 0; i < total; i++) begin
         if ($urandom_range(0, 99) < noise_pct)
            send_word($urandom, $urandom, $urandom, 1'b1);
         send_random_pixel();
      end
      if (count < 0) drain_frame();
   endtask

   // ---------------- tests ----------------
   task automatic test_reset_defaults();
      // 640 x 480, window 3 after reset: a partial frame with extreme samples
      send_word(8'h00, 8'h00, 8'h00, 1'b0);
      send_word(8'hFF, 8'hFF, 8'hFF, 1'b0);
      send_word(8'hAA, 8'h55, 8'hAA, 1'b0);
      send_word(8'h55, 8'hAA, 8'h55, 1'b0);
      send_word(8'h00, 8'hFF, 8'h0F, 1'b1);
      send_word(8'hF0, 8'h01, 8'h80, 1'b0);
   endtask

   task automatic test_corner_configs();
      run_frame(1, 1, 1, -1, 0);          // single pixel
      run_frame(0, 0, 1, -1, 0);          // zero sizes act as one
      run_frame(3, 3, 7, -1, 0);          // window larger than image
      run_frame(2, 3, 0, -1, 0);          // even window: pass-through
      send_word(8'h12, 8'h34, 8'h56, 1'b1);  // flush gives nothing here
      run_frame(4095, 1, 3, 24, 0);       // width clamps to the maximum
      run_frame(2, 8191, 5, 20, 10);      // height clamps to the maximum
   endtask

   task automatic test_random_frames();
      int w, h, win, count;
      while (words_sent < 1150) begin
         no_idle = ($urandom_range(0, 5) == 0);
         w   = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         h   = $urandom_range(1, 6);
         win = $urandom_range(0, 9) < 8 ? (2 * $urandom_range(0, 3) + 1) : $urandom_range(0, 7);
         count = ($urandom_range(0, 9) == 0) ? $urandom_range(1, w * h) : -1;
         run_frame(w, h, win, count, ($urandom_range(0, 1) != 0) ? 10 : 0);
      end
      no_idle = 0;
   endtask

   task automatic test_backpressure();
      set_geometry(8, 6, 3);
      fork
         begin
            hold_rsp = 1;
            repeat (HOLD_CYC) @(posedge clock);
            hold_rsp = 0;
         end
         begin
            for (int i = 0; i < 48; i++) send_random_pixel();
            drain_frame();
         end
      join
   endtask

   // ---------------- result checker ----------------
   initial begin
      int            gap;
      pixel_out_type exp_px;
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 5);
         if (gap > 0 || hold_rsp) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
            while (hold_rsp) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_ch.valid) @(posedge clock);
         if (pending_pixels.size() == 0) begin
            $display("%0t: unexpected word r=%h g=%h b=%h eof=%b err=%b", $time,
                     rsp_ch.red_out, rsp_ch.green_out, rsp_ch.blue_out,
                     rsp_ch.end_of_frame, rsp_ch.window_error);
            error_count++;
         end else begin
            exp_px = pending_pixels.pop_front();
            if (rsp_ch.red_out !== exp_px.red) begin
               $display("%0t: red expected %h actual %h", $time, exp_px.red,
                        rsp_ch.red_out);
               error_count++;
            end
            if (rsp_ch.green_out !== exp_px.green) begin
               $display("%0t: green expected %h actual %h", $time, exp_px.green,
                        rsp_ch.green_out);
               error_count++;
            end
            if (rsp_ch.blue_out !== exp_px.blue) begin
               $display("%0t: blue expected %h actual %h", $time, exp_px.blue,
                        rsp_ch.blue_out);
               error_count++;
            end
            if (rsp_ch.end_of_frame !== exp_px.eof) begin
               $display("%0t: end_of_frame expected %b actual %b", $time, exp_px.eof,
                        rsp_ch.end_of_frame);
               error_count++;
            end
            if (rsp_ch.window_error !== exp_px.werr) begin
               $display("%0t: window_error expected %b actual %b", $time, exp_px.werr,
                        rsp_ch.window_error);
               error_count++;
            end
         end
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || csr_psel)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------- main sequence ----------------
   initial begin
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.red_in   <= 8'h00;
      req_ch.green_in <= 8'h00;
      req_ch.blue_in  <= 8'h00;
      req_ch.flush    <= 1'b0;
      csr_psel        <= 1'b0;
      csr_penable     <= 1'b0;
      csr_pwrite      <= 1'b0;
      csr_paddr       <= 4'h0;
      csr_pwdata      <= 32'h0;
      error_count = 0;
      words_sent  = 0;
      idle_cycles = 0;
      hold_rsp    = 0;
      no_idle     = 0;
      cfg_width  = 12'd640;
      cfg_height = 13'd480;
      cfg_win    = 3'd3;
      restart_frame();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_corner_configs();
      test_backpressure();
      test_random_frames();

      wait_idle();
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/cwmf_pkg.sv
hdl/cwmf_ifs.sv
hdl/cwmf_csr.sv
hdl/cwmf_line_store.sv
hdl/cwmf_core.sv
hdl/clipped_window_median_filter.sv
tb/tb_top.sv
